// ===== hw/rtl/linear_block_remap_splitter_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the linear block remap splitter
// Shared concurrent assertion forms used by the RTL.
// ---------------------------------------------------------------------------
`ifndef LINEAR_BLOCK_REMAP_SPLITTER_CORE_MACROS_SVH
`define LINEAR_BLOCK_REMAP_SPLITTER_CORE_MACROS_SVH

// same-cycle implication
`define LBRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lbrs_pkg.sv =====
// ---------------------------------------------------------------------------
// lbrs_pkg
// Types and codes shared by the linear block remap splitter.
// ---------------------------------------------------------------------------
package lbrs_pkg;

	localparam int RESULT_LIMIT = 16;
	localparam int QUEUE_DEPTH  = 2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISALIGN = 2'd1;
	localparam logic [1:0] ST_BEYOND   = 2'd2;
	localparam logic [1:0] ST_HOLE     = 2'd3;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_REQ  = 1'b1;

	typedef struct packed {
		logic        action;
		logic        write_flag;
		logic [40:0] request_byte_offset;
		logic [40:0] request_byte_count;
		logic [47:0] buffer_base;
		logic [3:0]  entry_index;
		logic [31:0] entry_start_sector;
		logic [31:0] entry_sector_count;
		logic [31:0] entry_target_sector;
		logic [3:0]  entry_target_device;
	} lbrs_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  target_device;
		logic [41:0] target_byte_offset;
		logic [47:0] buffer_address;
		logic [40:0] piece_byte_count;
		logic        write_out;
		logic        last;
	} lbrs_out_t;

	// classified word passed from front to back
	typedef struct packed {
		logic        action;
		logic        write_flag;
		logic        early;
		logic [1:0]  early_status;
		logic        zero;
		logic        in_range;
		logic [40:0] offset;
		logic [41:0] finish;
		logic [47:0] buffer_base;
		logic [3:0]  entry_index;
		logic [31:0] first_sector;
		logic [31:0] sector_count;
		logic [31:0] target_sector;
		logic [3:0]  target_device;
	} lbrs_cmd_t;

endpackage

// ===== hw/rtl/linear_block_remap_splitter_core.sv =====
// ---------------------------------------------------------------------------
// linear_block_remap_splitter_core
// Linear device mapper: segment table loads and block request splitting.
// ---------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy rises only when
// the two-entry queue between front and back is full. Results come out on
// result for one cycle each, marked by result_valid, and cannot be held off.
// The back end takes one queued word at a time: a load, a rejected request
// or a zero-length request gives its single result in the cycle after it
// leaves the queue; a request that passes the checks leaves the queue, then
// goes through three steps per piece (slot compare, highest-hit select,
// piece emit) until its last piece or a hole status. Up to two further words
// are taken meanwhile.
module linear_block_remap_splitter_core #(
	parameter int SECTOR_BYTES = 512,
	parameter int BLOCK_BYTES  = 4096,
	parameter int MAX_SEGMENTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  lbrs_pkg::lbrs_in_t  command,
	output logic                result_valid,
	output lbrs_pkg::lbrs_out_t result
);
	import lbrs_pkg::*;

	lbrs_cmd_t push_cmd;
	lbrs_cmd_t head;
	logic      push;
	logic      pop;
	logic      full;
	logic      empty;

	lbrs_front #(
		.SECTOR_BYTES (SECTOR_BYTES),
		.BLOCK_BYTES  (BLOCK_BYTES),
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_front (
		.start   (start),
		.busy    (busy),
		.command (command),
		.full    (full),
		.push    (push),
		.cmd     (push_cmd)
	);

	lbrs_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_cmd),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	lbrs_back #(
		.SECTOR_BYTES (SECTOR_BYTES),
		.BLOCK_BYTES  (BLOCK_BYTES),
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== hw/rtl/lbrs_front.sv =====
// ---------------------------------------------------------------------------
// lbrs_front
// Accepts words, checks alignment and slot range, forms queue entries.
// ---------------------------------------------------------------------------
module lbrs_front #(
	parameter int SECTOR_BYTES = 512,
	parameter int BLOCK_BYTES  = 4096,
	parameter int MAX_SEGMENTS = 16
) (
	input  logic               start,
	output logic               busy,
	input  lbrs_pkg::lbrs_in_t command,
	input  logic               full,
	output logic               push,
	output lbrs_pkg::lbrs_cmd_t cmd
);
	import lbrs_pkg::*;

	localparam int SPB = ((BLOCK_BYTES / SECTOR_BYTES) != 0) ?
		(BLOCK_BYTES / SECTOR_BYTES) : 1;

	logic req_misalign;
	logic load_misalign;
	logic in_range;

	assign busy = full;
	assign push = start && !full;

	assign req_misalign =
		((command.request_byte_offset & 41'(BLOCK_BYTES - 1)) != '0) ||
		((command.request_byte_count  & 41'(BLOCK_BYTES - 1)) != '0);

	assign load_misalign = (command.entry_sector_count != '0) && (
		((command.entry_start_sector  & 32'(SPB - 1)) != '0) ||
		((command.entry_sector_count  & 32'(SPB - 1)) != '0) ||
		((command.entry_target_sector & 32'(SPB - 1)) != '0));

	assign in_range = 7'(command.entry_index) < 7'(MAX_SEGMENTS);

	always_comb begin
		cmd               = '0;
		cmd.action        = command.action;
		cmd.write_flag    = command.write_flag;
		cmd.in_range      = in_range;
		cmd.offset        = command.request_byte_offset;
		cmd.finish        = 42'(command.request_byte_offset) +
			42'(command.request_byte_count);
		cmd.buffer_base   = command.buffer_base;
		cmd.entry_index   = command.entry_index;
		cmd.first_sector  = command.entry_start_sector;
		cmd.sector_count  = command.entry_sector_count;
		cmd.target_sector = command.entry_target_sector;
		cmd.target_device = command.entry_target_device;
		cmd.zero          = (command.request_byte_count == '0);
		unique case (command.action)
			ACT_LOAD: begin
				cmd.early = 1'b1;
				if (!in_range) begin
					cmd.early_status = ST_BEYOND;
				end else if (load_misalign) begin
					cmd.early_status = ST_MISALIGN;
				end else begin
					cmd.early_status = ST_OK;
				end
			end
			ACT_REQ: begin
				cmd.early        = req_misalign;
				cmd.early_status = ST_MISALIGN;
			end
			default: begin
				cmd.early        = 1'b1;
				cmd.early_status = ST_OK;
			end
		endcase
	end

endmodule

// ===== hw/rtl/lbrs_fifo.sv =====
// ---------------------------------------------------------------------------
// lbrs_fifo
// Short queue of classified words between front and back.
// ---------------------------------------------------------------------------
module lbrs_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  lbrs_pkg::lbrs_cmd_t wdata,
	input  logic                pop,
	output lbrs_pkg::lbrs_cmd_t rdata,
	output logic                full,
	output logic                empty
);
	import lbrs_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	lbrs_cmd_t          entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/lbrs_back.sv =====
// ---------------------------------------------------------------------------
// lbrs_back
// Segment table, end check and request splitting into pieces.
// ---------------------------------------------------------------------------
`include "linear_block_remap_splitter_core_macros.svh"

module lbrs_back #(
	parameter int SECTOR_BYTES = 512,
	parameter int BLOCK_BYTES  = 4096,
	parameter int MAX_SEGMENTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  lbrs_pkg::lbrs_cmd_t head,
	input  logic                empty,
	output logic                pop,
	output logic                result_valid,
	output lbrs_pkg::lbrs_out_t result
);
	import lbrs_pkg::*;

	localparam int SB_LG  = $clog2(SECTOR_BYTES);
	localparam int BB_LG  = $clog2(BLOCK_BYTES);
	localparam int SPB_LG = (BB_LG > SB_LG) ? (BB_LG - SB_LG) : 0;
	localparam int SLOT_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int LO_W   = 32 + SB_LG;
	localparam int CMP_W  = 33 + SB_LG;
	localparam int TO_W   = CMP_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_PICK,
		S_EMIT
	} state_t;

	state_t             state_q;

	logic [31:0]        seg_start_q  [MAX_SEGMENTS];
	logic [31:0]        seg_count_q  [MAX_SEGMENTS];
	logic [31:0]        seg_target_q [MAX_SEGMENTS];
	logic [3:0]         seg_device_q [MAX_SEGMENTS];
	logic [35:0]        total_q;

	logic               cur_wr_q;
	logic [40:0]        cur_base_q;
	logic [41:0]        cur_finish_q;
	logic [47:0]        cur_buf_q;
	logic [41:0]        off_q;
	logic [3:0]         n_q;

	logic [MAX_SEGMENTS-1:0] hit_s1;
	logic               any_s2;
	logic [LO_W-1:0]    sel_lo_s2;
	logic [CMP_W-1:0]   sel_hi_s2;
	logic [31:0]        sel_tgt_s2;
	logic [3:0]         sel_dev_s2;

	logic [SLOT_W-1:0]  slot;
	logic [35:0]        new_total;
	logic               beyond;
	logic [LO_W-1:0]    lo_c [MAX_SEGMENTS];
	logic [CMP_W-1:0]   hi_c [MAX_SEGMENTS];
	logic [MAX_SEGMENTS-1:0] hit_c;
	logic [SLOT_W-1:0]  sel_c;
	logic               any_c;
	logic [41:0]        rem;
	logic [CMP_W-1:0]   seg_left;
	logic [41:0]        len;
	logic               piece_end;
	logic [TO_W-1:0]    toff;
	logic [47:0]        addr;
	lbrs_out_t          piece_c;

	function automatic lbrs_out_t status_word(logic [1:0] st, logic wr);
		lbrs_out_t w;
		w           = '0;
		w.status    = st;
		w.write_out = wr;
		w.last      = 1'b1;
		return w;
	endfunction

	assign pop       = (state_q == S_IDLE) && !empty;
	assign slot      = SLOT_W'(head.entry_index);
	assign new_total = total_q - 36'(seg_count_q[slot]) + 36'(head.sector_count);
	assign beyond    = (head.finish >> BB_LG) > 42'(total_q >> SPB_LG);

	always_comb begin
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			lo_c[i]  = LO_W'(seg_start_q[i]) << SB_LG;
			hi_c[i]  = (CMP_W'(seg_start_q[i]) + CMP_W'(seg_count_q[i])) << SB_LG;
			hit_c[i] = (seg_count_q[i] != '0) &&
				(CMP_W'(lo_c[i]) <= CMP_W'(off_q)) && (CMP_W'(off_q) < hi_c[i]);
		end
	end

	// highest slot wins
	always_comb begin
		sel_c = '0;
		any_c = 1'b0;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			if (hit_s1[i]) begin
				sel_c = SLOT_W'(i);
				any_c = 1'b1;
			end
		end
	end

	always_comb begin
		rem       = cur_finish_q - off_q;
		seg_left  = sel_hi_s2 - CMP_W'(off_q);
		len       = (seg_left < CMP_W'(rem)) ? 42'(seg_left) : rem;
		piece_end = (len == rem);
		toff      = TO_W'(CMP_W'(off_q) - CMP_W'(sel_lo_s2)) +
			(TO_W'(sel_tgt_s2) << SB_LG);
		addr      = cur_buf_q + 48'(off_q - 42'(cur_base_q));
		piece_c                    = '0;
		piece_c.status             = ST_OK;
		piece_c.target_device      = sel_dev_s2;
		piece_c.target_byte_offset = 42'(toff);
		piece_c.buffer_address     = addr;
		piece_c.piece_byte_count   = 41'(len);
		piece_c.write_out          = cur_wr_q;
		piece_c.last               = piece_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			result       <= '0;
			total_q      <= '0;
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				seg_start_q[i]  <= '0;
				seg_count_q[i]  <= '0;
				seg_target_q[i] <= '0;
				seg_device_q[i] <= '0;
			end
			cur_wr_q     <= 1'b0;
			cur_base_q   <= '0;
			cur_finish_q <= '0;
			cur_buf_q    <= '0;
			off_q        <= '0;
			n_q          <= '0;
			hit_s1       <= '0;
			any_s2       <= 1'b0;
			sel_lo_s2    <= '0;
			sel_hi_s2    <= '0;
			sel_tgt_s2   <= '0;
			sel_dev_s2   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!empty) begin
						if (head.action == ACT_LOAD) begin
							if (head.early_status == ST_OK) begin
								seg_count_q[slot] <= head.sector_count;
								total_q           <= new_total;
								if (head.sector_count == '0) begin
									seg_start_q[slot]  <= '0;
									seg_target_q[slot] <= '0;
									seg_device_q[slot] <= '0;
								end else begin
									seg_start_q[slot]  <= head.first_sector;
									seg_target_q[slot] <= head.target_sector;
									seg_device_q[slot] <= head.target_device;
								end
							end
							result_valid <= 1'b1;
							result       <= status_word(head.early_status, 1'b0);
						end else if (head.early) begin
							result_valid <= 1'b1;
							result       <= status_word(head.early_status, head.write_flag);
						end else if (beyond) begin
							result_valid <= 1'b1;
							result       <= status_word(ST_BEYOND, head.write_flag);
						end else if (head.zero) begin
							result_valid <= 1'b1;
							result       <= status_word(ST_OK, head.write_flag);
						end else begin
							result_valid <= 1'b0;
							cur_wr_q     <= head.write_flag;
							cur_base_q   <= head.offset;
							cur_finish_q <= head.finish;
							cur_buf_q    <= head.buffer_base;
							off_q        <= 42'(head.offset);
							n_q          <= '0;
							state_q      <= S_LOOKUP;
						end
					end else begin
						result_valid <= 1'b0;
					end
				end
				S_LOOKUP: begin
					result_valid <= 1'b0;
					hit_s1       <= hit_c;
					state_q      <= S_PICK;
				end
				S_PICK: begin
					result_valid <= 1'b0;
					any_s2       <= any_c;
					sel_lo_s2    <= lo_c[sel_c];
					sel_hi_s2    <= hi_c[sel_c];
					sel_tgt_s2   <= seg_target_q[sel_c];
					sel_dev_s2   <= seg_device_q[sel_c];
					state_q      <= S_EMIT;
				end
				S_EMIT: begin
					result_valid <= 1'b1;
					if (!any_s2) begin
						result  <= status_word(ST_HOLE, cur_wr_q);
						state_q <= S_IDLE;
					end else if (n_q == 4'(RESULT_LIMIT - 1) && !piece_end) begin
						result  <= status_word(ST_HOLE, cur_wr_q);
						state_q <= S_IDLE;
					end else begin
						result  <= piece_c;
						off_q   <= off_q + len;
						n_q     <= n_q + 1'b1;
						state_q <= piece_end ? S_IDLE : S_LOOKUP;
					end
				end
				default: begin
					result_valid <= 1'b0;
					state_q      <= S_IDLE;
				end
			endcase
		end
	end

	`LBRS_ASSERT_IMP(a_status_ends_word, clk, arst_n, result_valid && result.status != ST_OK, result.last, "error status on a non-final result")
	`LBRS_ASSERT_NXT(a_piece_gap, clk, arst_n, result_valid && !result.last, !result_valid, "pieces emitted back to back")
	`LBRS_ASSERT_IMP(a_piece_aligned, clk, arst_n, result_valid && result.piece_byte_count != '0, (result.piece_byte_count & 41'(BLOCK_BYTES - 1)) == '0, "piece length not block aligned")

endmodule

// ===== tb/linear_block_remap_splitter_core_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// linear_block_remap_splitter_core_tb
// Drives segment loads and block requests into the mapper: a short directed
// table first, then constrained-by-hand random traffic. Each result word is
// checked against a given word or a local model of the table and splitter.
// ---------------------------------------------------------------------------
module linear_block_remap_splitter_core_tb;
	import lbrs_pkg::*;

	localparam int SECTOR_BYTES = 512;
	localparam int BLOCK_BYTES  = 4096;
	localparam int MAX_SEGMENTS = 16;

	localparam longint unsigned SECTOR_B = SECTOR_BYTES;
	localparam longint unsigned BLOCK_B  = BLOCK_BYTES;
	localparam longint unsigned SEC_PER_BLK =
		(BLOCK_BYTES / SECTOR_BYTES) != 0 ? (BLOCK_BYTES / SECTOR_BYTES) : 1;

	localparam int RANDOM_WORDS = 270;
	localparam int MAX_GAP      = 18;
	localparam int WATCHDOG     = 1000;
	localparam int SETTLE       = 60;
	localparam int SHOW_LIMIT   = 10;

	typedef struct {
		lbrs_in_t  word;
		bit        typed;
		lbrs_out_t want;
	} plan_row_t;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	lbrs_in_t  command;
	logic      result_valid;
	lbrs_out_t result;

	// model of the segment table
	logic [31:0] slot_start  [MAX_SEGMENTS];
	logic [31:0] slot_len    [MAX_SEGMENTS];
	logic [31:0] slot_target [MAX_SEGMENTS];
	logic [3:0]  slot_dev    [MAX_SEGMENTS];
	logic [35:0] mapped_sectors;

	lbrs_out_t fresh_pieces [$];
	lbrs_out_t pending      [$];
	plan_row_t plan         [$];

	int  faults;
	int  shown;
	int  idle_cycles;
	bit  burst;

	linear_block_remap_splitter_core #(
		.SECTOR_BYTES(SECTOR_BYTES),
		.BLOCK_BYTES (BLOCK_BYTES),
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.command     (command),
		.result_valid(result_valid),
		.result      (result)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic lbrs_out_t bare_status(input logic [1:0] st, input logic wr);
		lbrs_out_t r;
		r           = '0;
		r.status    = st;
		r.write_out = wr;
		r.last      = 1'b1;
		return r;
	endfunction

	function automatic lbrs_in_t mk_load(input logic [3:0] idx, input logic [31:0] st,
			input logic [31:0] cnt, input logic [31:0] tg, input logic [3:0] dev);
		lbrs_in_t w;
		w                     = '0;
		w.action              = ACT_LOAD;
		w.entry_index         = idx;
		w.entry_start_sector  = st;
		w.entry_sector_count  = cnt;
		w.entry_target_sector = tg;
		w.entry_target_device = dev;
		return w;
	endfunction

	function automatic lbrs_in_t mk_req(input logic wr, input logic [40:0] off,
			input logic [40:0] cnt, input logic [47:0] bufb);
		lbrs_in_t w;
		w                     = '0;
		w.action              = ACT_REQ;
		w.write_flag          = wr;
		w.request_byte_offset = off;
		w.request_byte_count  = cnt;
		w.buffer_base         = bufb;
		return w;
	endfunction

	function automatic int next_gap();
		return burst ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	// updates the table model and leaves the expected words in fresh_pieces
	task automatic map_word(input lbrs_in_t w);
		longint unsigned base_off, cnt, fin, off, lo, hi, seg_lo, seg_hi, len;
		logic [63:0] sum;
		int hit, n;
		bit done;
		lbrs_out_t r;
		fresh_pieces.delete();
		if (w.action == ACT_LOAD) begin
			if (int'(w.entry_index) >= MAX_SEGMENTS) begin
				fresh_pieces.push_back(bare_status(ST_BEYOND, 1'b0));
			end else if (w.entry_sector_count != 0 &&
					((w.entry_start_sector % SEC_PER_BLK) != 0 ||
					 (w.entry_sector_count % SEC_PER_BLK) != 0 ||
					 (w.entry_target_sector % SEC_PER_BLK) != 0)) begin
				fresh_pieces.push_back(bare_status(ST_MISALIGN, 1'b0));
			end else begin
				if (w.entry_sector_count == 0) begin
					slot_start[w.entry_index]  = '0;
					slot_len[w.entry_index]    = '0;
					slot_target[w.entry_index] = '0;
					slot_dev[w.entry_index]    = '0;
				end else begin
					slot_start[w.entry_index]  = w.entry_start_sector;
					slot_len[w.entry_index]    = w.entry_sector_count;
					slot_target[w.entry_index] = w.entry_target_sector;
					slot_dev[w.entry_index]    = w.entry_target_device;
				end
				sum = '0;
				for (int i = 0; i < MAX_SEGMENTS; i++)
					sum += slot_len[i];
				mapped_sectors = sum[35:0];
				fresh_pieces.push_back(bare_status(ST_OK, 1'b0));
			end
		end else begin
			base_off = 64'(w.request_byte_offset);
			cnt      = 64'(w.request_byte_count);
			fin      = base_off + cnt;
			if ((base_off % BLOCK_B) != 0 || (cnt % BLOCK_B) != 0) begin
				fresh_pieces.push_back(bare_status(ST_MISALIGN, w.write_flag));
			end else if (fin / BLOCK_B > mapped_sectors / SEC_PER_BLK) begin
				fresh_pieces.push_back(bare_status(ST_BEYOND, w.write_flag));
			end else if (cnt == 0) begin
				fresh_pieces.push_back(bare_status(ST_OK, w.write_flag));
			end else begin
				off  = base_off;
				n    = 0;
				done = 1'b0;
				while (off != fin && !done) begin
					hit    = -1;
					seg_lo = 0;
					seg_hi = 0;
					for (int i = 0; i < MAX_SEGMENTS; i++) begin
						if (slot_len[i] != 0) begin
							lo = longint'(slot_start[i]) * SECTOR_B;
							hi = (longint'(slot_start[i]) + longint'(slot_len[i])) * SECTOR_B;
							if (lo <= off && off < hi) begin
								hit    = i;
								seg_lo = lo;
								seg_hi = hi;
							end
						end
					end
					if (hit < 0) begin
						fresh_pieces.push_back(bare_status(ST_HOLE, w.write_flag));
						done = 1'b1;
					end else begin
						len = fin - off;
						if (seg_hi - off < len)
							len = seg_hi - off;
						if (n == RESULT_LIMIT - 1 && off + len != fin) begin
							fresh_pieces.push_back(bare_status(ST_HOLE, w.write_flag));
							done = 1'b1;
						end else begin
							r                    = '0;
							r.status             = ST_OK;
							r.target_device      = slot_dev[hit];
							r.target_byte_offset = 42'((off - seg_lo) +
								longint'(slot_target[hit]) * SECTOR_B);
							r.buffer_address     = 48'(longint'(w.buffer_base) + (off - base_off));
							r.piece_byte_count   = 41'(len);
							r.write_out          = w.write_flag;
							r.last               = (off + len == fin);
							fresh_pieces.push_back(r);
							n++;
							off += len;
						end
					end
				end
			end
		end
	endtask

	task automatic add_row(input lbrs_in_t w, input bit typed, input lbrs_out_t want);
		plan_row_t row;
		row.word  = w;
		row.typed = typed;
		row.want  = want;
		plan.push_back(row);
	endtask

	task automatic issue_word(input lbrs_in_t w, input int gap, input bit typed,
			input lbrs_out_t want);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		command <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		map_word(w);
		if (typed)
			pending.push_back(want);
		else
			foreach (fresh_pieces[i])
				pending.push_back(fresh_pieces[i]);
		@(negedge clk);
	endtask

	task automatic drain_pieces();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending.size() != 0);
	endtask

	task automatic draw_word(output lbrs_in_t w);
		int kind, pick;
		longint unsigned tot_blk, lim;
		w.action              = ACT_LOAD;
		w.write_flag          = 1'($urandom_range(0, 1));
		w.request_byte_offset = 41'({$urandom, $urandom});
		w.request_byte_count  = 41'({$urandom, $urandom});
		w.buffer_base         = 48'({$urandom, $urandom});
		w.entry_index         = 4'($urandom_range(0, 15));
		w.entry_start_sector  = $urandom;
		w.entry_sector_count  = $urandom;
		w.entry_target_sector = $urandom;
		w.entry_target_device = 4'($urandom_range(0, 15));
		kind    = $urandom_range(0, 99);
		tot_blk = mapped_sectors / SEC_PER_BLK;
		lim     = tot_blk < 300 ? tot_blk : 300;
		if (kind < 28) begin
			w.entry_start_sector  = 32'($urandom_range(0, 255) * SEC_PER_BLK);
			w.entry_sector_count  = 32'($urandom_range(1, 32) * SEC_PER_BLK);
			w.entry_target_sector = $urandom & 32'hFFFF_FFF8;
		end else if (kind < 31) begin
			w.entry_sector_count = '0;
		end else if (kind < 34) begin
			pick = $urandom_range(0, 2);
			w.entry_start_sector  &= 32'hFFFF_FFF8;
			w.entry_sector_count  &= 32'hFFFF_FFF8;
			w.entry_target_sector &= 32'hFFFF_FFF8;
			case (pick)
				0: w.entry_start_sector  |= $urandom_range(1, 7);
				1: w.entry_sector_count  |= $urandom_range(1, 7);
				default: w.entry_target_sector |= $urandom_range(1, 7);
			endcase
		end else if (kind < 36) begin
			w.entry_start_sector  &= 32'hFFFF_FFF8;
			w.entry_sector_count  &= 32'hFFFF_FFF8;
			w.entry_target_sector &= 32'hFFFF_FFF8;
		end else if (kind < 96) begin
			w.action              = ACT_REQ;
			w.request_byte_offset = 41'($urandom_range(0, int'(lim)) * BLOCK_B);
			w.request_byte_count  = 41'($urandom_range(1, 20) * BLOCK_B);
			if (kind >= 90 && kind < 93) begin
				w.request_byte_count = '0;
			end else if (kind >= 93) begin
				if ($urandom_range(0, 1))
					w.request_byte_offset |= 41'($urandom_range(1, BLOCK_BYTES - 1));
				else
					w.request_byte_count |= 41'($urandom_range(1, BLOCK_BYTES - 1));
			end
		end else begin
			w.action = 1'($urandom_range(0, 1));
		end
	endtask

	// result checker
	always @(posedge clk) begin
		lbrs_out_t want;
		if (arst_n && result_valid) begin
			if (pending.size() == 0) begin
				faults++;
				if (shown < SHOW_LIMIT) begin
					shown++;
					$display("unexpected word: st=%0d dev=%0d toff=%h buf=%h len=%h wr=%b last=%b",
						result.status, result.target_device, result.target_byte_offset,
						result.buffer_address, result.piece_byte_count, result.write_out,
						result.last);
				end
			end else begin
				want = pending.pop_front();
				if (result.status !== want.status ||
						result.target_device !== want.target_device ||
						result.target_byte_offset !== want.target_byte_offset ||
						result.buffer_address !== want.buffer_address ||
						result.piece_byte_count !== want.piece_byte_count ||
						result.write_out !== want.write_out ||
						result.last !== want.last) begin
					faults++;
					if (shown < SHOW_LIMIT) begin
						shown++;
						$display("mismatch exp: st=%0d dev=%0d toff=%h buf=%h len=%h wr=%b last=%b",
							want.status, want.target_device, want.target_byte_offset,
							want.buffer_address, want.piece_byte_count, want.write_out,
							want.last);
						$display("         got: st=%0d dev=%0d toff=%h buf=%h len=%h wr=%b last=%b",
							result.status, result.target_device, result.target_byte_offset,
							result.buffer_address, result.piece_byte_count, result.write_out,
							result.last);
					end
				end
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		lbrs_in_t w;
		faults      = 0;
		shown       = 0;
		idle_cycles = 0;
		burst       = 1'b0;
		start       = 1'b0;
		command     = '0;
		arst_n      = 1'b0;
		mapped_sectors = '0;
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			slot_start[i]  = '0;
			slot_len[i]    = '0;
			slot_target[i] = '0;
			slot_dev[i]    = '0;
		end
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table, then rejections
		add_row(mk_req(1'b0, 41'd0, 41'd4096, 48'd0), 1'b1, bare_status(ST_BEYOND, 1'b0));
		add_row(mk_req(1'b1, 41'd0, 41'd0, '1), 1'b1, bare_status(ST_OK, 1'b1));
		add_row(mk_req(1'b0, 41'd512, 41'd4096, 48'd0), 1'b1, bare_status(ST_MISALIGN, 1'b0));
		add_row(mk_req(1'b1, 41'd0, 41'd100, 48'd0), 1'b1, bare_status(ST_MISALIGN, 1'b1));
		add_row(mk_load(4'd0, 32'd3, 32'd8, 32'd0, 4'd1), 1'b1, bare_status(ST_MISALIGN, 1'b0));
		add_row(mk_load(4'd0, 32'd0, 32'd9, 32'd0, 4'd1), 1'b1, bare_status(ST_MISALIGN, 1'b0));
		add_row(mk_load(4'd0, 32'd0, 32'd8, 32'd4, 4'd1), 1'b1, bare_status(ST_MISALIGN, 1'b0));
		add_row(mk_load(4'd4, '1, 32'd0, '1, 4'd15), 1'b1, bare_status(ST_OK, 1'b0));
		// overlapping layout: slot 2 sits over the top half of slot 0
		add_row(mk_load(4'd0, 32'd0, 32'd64, 32'd8000, 4'd3), 1'b1, bare_status(ST_OK, 1'b0));
		add_row(mk_load(4'd1, 32'd64, 32'd64, 32'd0, 4'd5), 1'b1, bare_status(ST_OK, 1'b0));
		add_row(mk_load(4'd2, 32'd32, 32'd32, 32'd8, 4'd7), 1'b1, bare_status(ST_OK, 1'b0));
		add_row(mk_load(4'd15, 32'hFFFF_FFF8, 32'd8, 32'hFFFF_FFF8, 4'd15), 1'b1,
			bare_status(ST_OK, 1'b0));
		add_row(mk_req(1'b0, 41'd0, 41'd65536, 48'h1000), 1'b0, '0);
		add_row(mk_req(1'b1, 41'd65536, 41'd20480, 48'd0), 1'b1, bare_status(ST_HOLE, 1'b1));
		add_row(mk_req(1'b1, 41'd65536, 41'd24576, 48'd0), 1'b1, bare_status(ST_BEYOND, 1'b1));
		add_row(mk_req(1'b0, 41'h1FF_FFFF_F000, 41'd4096, '1), 1'b1,
			bare_status(ST_BEYOND, 1'b0));
		add_row(mk_req(1'b1, 41'd12288, 41'd12288, 48'hFFFF_FFFF_F800), 1'b0, '0);
		add_row(mk_load(4'd3, 32'd0, 32'hFFFF_FFF8, 32'd0, 4'd9), 1'b1, bare_status(ST_OK, 1'b0));
		add_row(mk_req(1'b0, 41'h1FF_FFFF_F000, 41'd4096, 48'd0), 1'b0, '0);
		add_row(mk_req(1'b1, 41'd0, 41'h1FF_FFFF_F000, '1), 1'b0, '0);
		// small slots punched into slot 3 to overrun the piece limit
		for (int k = 0; k < 8; k++)
			add_row(mk_load(4'(4 + k), 32'(8000 + 16 * k), 32'd8, 32'(16 * k), 4'(k)), 1'b1,
				bare_status(ST_OK, 1'b0));
		add_row(mk_req(1'b0, 41'(999 * 4096), 41'(17 * 4096), 48'h2000), 1'b0, '0);
		add_row(mk_load(4'd3, 32'd0, 32'd0, 32'd0, 4'd0), 1'b1, bare_status(ST_OK, 1'b0));

		foreach (plan[i])
			issue_word(plan[i].word, next_gap(), plan[i].typed, plan[i].want);
		drain_pieces();

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 25 == 0)
				burst = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_WORDS / 2)
				drain_pieces();
			draw_word(w);
			issue_word(w, next_gap(), 1'b0, '0);
		end
		drain_pieces();
		repeat (SETTLE) @(negedge clk);

		if (faults == 0 && pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
